>>> rtl/fed_pkg.sv
// Shared constants, types and saturation helpers for the feedback echo delay.
`default_nettype none
package fed_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int GAIN_BITS      = 15;
   localparam int DELAY_BITS     = 16;
   localparam int RING_ADDR_BITS = 16;
   localparam int RING_DEPTH     = 1 << RING_ADDR_BITS;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int COUNT_BITS     = $clog2(GAIN_BITS + 1);

   localparam logic [DELAY_BITS-1:0] DELAY_RESET    = DELAY_BITS'(17640);
   localparam logic [GAIN_BITS-1:0]  FEEDBACK_RESET = GAIN_BITS'(16384);
   localparam logic [GAIN_BITS-1:0]  WET_RESET      = GAIN_BITS'(16384);
   localparam logic [GAIN_BITS-1:0]  OUTPUT_RESET   = GAIN_BITS'(9830);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SAMPLE_BITS+1:0] wide_type;

   typedef enum logic [1:0] {
      REG_DELAY    = 2'd0,
      REG_FEEDBACK = 2'd1,
      REG_WET      = 2'd2,
      REG_OUTPUT   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [DELAY_BITS-1:0] delay_samples;
      logic [GAIN_BITS-1:0]  feedback_gain;
      logic [GAIN_BITS-1:0]  wet_gain;
      logic [GAIN_BITS-1:0]  output_gain;
   } cfg_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ring_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_MUL_WET,
      ST_MIX,
      ST_MUL_OUT,
      ST_FINISH
   } state_type;

   function automatic sample_type sat_wide(input wide_type v);
      wide_type hi_lim;
      wide_type lo_lim;
      hi_lim = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
      lo_lim = {3'b111, {(SAMPLE_BITS-1){1'b0}}};
      if (v > hi_lim) begin
         return hi_lim[SAMPLE_BITS-1:0];
      end else if (v < lo_lim) begin
         return lo_lim[SAMPLE_BITS-1:0];
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic sample_type sat_add(input sample_type a, input sample_type b);
      wide_type sum;
      sum = {{2{a[SAMPLE_BITS-1]}}, a} + {{2{b[SAMPLE_BITS-1]}}, b};
      return sat_wide(sum);
   endfunction

endpackage
`default_nettype wire

>>> rtl/fed_serial_mult.sv
// Bit-serial Q1.15 multiplier: one gain bit per cycle, round half up, saturate.
`default_nettype none
module fed_serial_mult
   import fed_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire sample_type           x,
   input  wire logic [GAIN_BITS-1:0] g,
   output logic                      done,
   output sample_type                product
);

   logic signed [SAMPLE_BITS:0] hi_ff, hi_in;
   logic [GAIN_BITS-1:0]        lo_ff, lo_in;
   sample_type                  x_ff, x_in;
   logic [COUNT_BITS-1:0]       count_ff, count_in;
   logic                        done_ff, done_in;
   wide_type                    addend;
   wide_type                    sum;
   wide_type                    rounded;

   always_comb begin
      addend = lo_ff[0] ? {{2{x_ff[SAMPLE_BITS-1]}}, x_ff} : '0;
      sum    = {hi_ff[SAMPLE_BITS], hi_ff} + addend;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      x_in     = x_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         hi_in    = '0;
         lo_in    = g;
         x_in     = x;
         count_in = COUNT_BITS'(GAIN_BITS);
      end else if (count_ff != '0) begin
         hi_in    = sum[SAMPLE_BITS+1:1];
         lo_in    = {sum[0], lo_ff[GAIN_BITS-1:1]};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == COUNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      x_ff  <= x_in;
   end

   // adding half an LSB carries into the high part exactly when the top low bit is set
   assign rounded = {hi_ff[SAMPLE_BITS], hi_ff} + wide_type'(lo_ff[GAIN_BITS-1]);
   assign product = sat_wide(rounded);
   assign done    = done_ff;

endmodule
`default_nettype wire

>>> rtl/fed_delay_ring.sv
// Delay ring memory with write pointer and fill tracking for unwritten entries.
`default_nettype none
module fed_delay_ring
   import fed_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ring_ctl_type          ctl,
   input  wire logic [DELAY_BITS-1:0] delay_samples,
   input  wire sample_type            wr_data,
   output sample_type                 rd_data
);

   logic [SAMPLE_BITS-1:0]             ring_mem [RING_DEPTH];
   logic [RING_ADDR_BITS-1:0]          wp_ff, wp_in;
   logic                               wrapped_ff, wrapped_in;
   logic [SAMPLE_BITS-1:0]             rd_data_ff;
   logic                               rd_hit_ff;
   logic [RING_ADDR_BITS+DELAY_BITS-1:0] delay_ext;
   logic [RING_ADDR_BITS-1:0]          rd_dist;
   logic [RING_ADDR_BITS-1:0]          rd_addr;

   assign delay_ext = (RING_ADDR_BITS+DELAY_BITS)'(delay_samples);
   assign rd_dist   = delay_ext[RING_ADDR_BITS-1:0];
   assign rd_addr   = wp_ff - rd_dist;

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (ctl.wr_en) begin
         wp_in = wp_ff + 1'b1;
         if (wp_ff == '1) begin
            wrapped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
         rd_hit_ff  <= wrapped_ff | (rd_addr < wp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         ring_mem[wp_ff] <= wr_data;
      end
   end

   // entries not yet written since reset read as silence
   assign rd_data = rd_hit_ff ? sample_type'(rd_data_ff) : '0;

endmodule
`default_nettype wire

>>> rtl/fed_csr.sv
// APB register file for delay and gain settings.
`default_nettype none
module fed_csr
   import fed_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready,
   output cfg_type                       cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_DELAY:    cfg_in.delay_samples = pwdata[DELAY_BITS-1:0];
            REG_FEEDBACK: cfg_in.feedback_gain = pwdata[GAIN_BITS-1:0];
            REG_WET:      cfg_in.wet_gain      = pwdata[GAIN_BITS-1:0];
            REG_OUTPUT:   cfg_in.output_gain   = pwdata[GAIN_BITS-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_DELAY:    prdata = CSR_DATA_BITS'(cfg_ff.delay_samples);
         REG_FEEDBACK: prdata = CSR_DATA_BITS'(cfg_ff.feedback_gain);
         REG_WET:      prdata = CSR_DATA_BITS'(cfg_ff.wet_gain);
         REG_OUTPUT:   prdata = CSR_DATA_BITS'(cfg_ff.output_gain);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_samples <= DELAY_RESET;
         cfg_ff.feedback_gain <= FEEDBACK_RESET;
         cfg_ff.wet_gain      <= WET_RESET;
         cfg_ff.output_gain   <= OUTPUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> rtl/feedback_echo_delay.sv
// Top level of the feedback echo delay: sequencer, result register and assertions.
// One transaction in gives one transaction out. Each sample passes through two
// back-to-back bit-serial multiplies (wet and feedback gains in parallel, then output
// gain), each one gain bit per cycle.
// A new sample is taken while the previous result waits on rsp_stall. The delay
// ring needs no clearing pass: entries not yet written since reset read as zero.
`default_nettype none
module feedback_echo_delay
   import fed_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire sample_type               req_dry_sample,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output sample_type                    rsp_out_sample,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   state_type    state_ff, state_in;
   cfg_type      cfg;
   ring_ctl_type ring_ctl;
   sample_type   dry_ff, dry_in;
   sample_type   wet;
   sample_type   mix;
   sample_type   fb;
   sample_type   mult_a_x;
   logic [GAIN_BITS-1:0] mult_a_g;
   logic         start_a, start_b;
   logic         done_a, done_b;
   sample_type   prod_a, prod_b;
   logic         req_accept;
   logic         out_load;
   logic         rsp_valid_ff, rsp_valid_in;
   sample_type   rsp_out_sample_ff, rsp_out_sample_in;

   fed_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fed_delay_ring u_ring (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ring_ctl),
      .delay_samples (cfg.delay_samples),
      .wr_data       (fb),
      .rd_data       (wet)
   );

   fed_serial_mult u_mult_a (
      .clock   (clock),
      .reset   (reset),
      .start   (start_a),
      .x       (mult_a_x),
      .g       (mult_a_g),
      .done    (done_a),
      .product (prod_a)
   );

   fed_serial_mult u_mult_b (
      .clock   (clock),
      .reset   (reset),
      .start   (start_b),
      .x       (wet),
      .g       (cfg.feedback_gain),
      .done    (done_b),
      .product (prod_b)
   );

   assign mix = sat_add(dry_ff, prod_a);
   assign fb  = sat_add(dry_ff, prod_b);

   assign req_accept = req_valid & ~req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_accept) state_in = ST_READ;
         ST_READ:    state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_MUL_WET;
         ST_MUL_WET: if (done_a) state_in = ST_MIX;
         ST_MIX:     state_in = ST_MUL_OUT;
         ST_MUL_OUT: if (done_a) state_in = ST_FINISH;
         ST_FINISH:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall      = 1'b1;
      ring_ctl.rd_en = 1'b0;
      ring_ctl.wr_en = 1'b0;
      start_a        = 1'b0;
      start_b        = 1'b0;
      out_load       = 1'b0;
      mult_a_x       = wet;
      mult_a_g       = cfg.wet_gain;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_READ: begin
            ring_ctl.rd_en = 1'b1;
         end
         ST_LOAD: begin
            start_a = 1'b1;
            start_b = 1'b1;
         end
         ST_MIX: begin
            ring_ctl.wr_en = 1'b1;
            start_a        = 1'b1;
            mult_a_x       = mix;
            mult_a_g       = cfg.output_gain;
         end
         ST_FINISH: begin
            out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      dry_in            = req_accept ? req_dry_sample : dry_ff;
      rsp_out_sample_in = out_load ? prod_a : rsp_out_sample_ff;
      rsp_valid_in      = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dry_ff            <= dry_in;
      rsp_out_sample_ff <= rsp_out_sample_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_out_sample_ff;

   // both gain multiplies start together and must finish together
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_WET) && done_a |-> done_b)
      else $error("wet and feedback multiplies out of step");

   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall && (state_ff == ST_READ))
      else $error("accepted transaction did not start processing");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result presented outside finish state");

   assert property (@(posedge clock) disable iff (reset)
      ring_ctl.wr_en |-> $past(done_a) && $past(state_ff) == ST_MUL_WET)
      else $error("ring write without finished gain multiply");

endmodule
`default_nettype wire

>>> bench/feedback_echo_delay_test.sv
// Self-checking testbench for the feedback echo delay: directed and random audio streams against a predictor.
`timescale 1ns / 100ps
module feedback_echo_delay_test;
   import fed_pkg::*;

   localparam longint SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 205;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sample_type req_dry_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   sample_type rsp_out_sample;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   sample_type pending_dry[$];
   sample_type expected_out[$];
   int send_idle_pct = 23;
   int recv_idle_pct = 62;
   int error_count = 0;
   int result_count = 0;
   logic hold_go = 1'b0;
   int hold_left = 0;

   // predictor state
   sample_type echo_ring [0:RING_DEPTH-1];
   logic [RING_ADDR_BITS-1:0] echo_wr_pos = '0;
   logic [DELAY_BITS-1:0] cfg_delay = DELAY_RESET;
   logic [GAIN_BITS-1:0] cfg_feedback = FEEDBACK_RESET;
   logic [GAIN_BITS-1:0] cfg_wet = WET_RESET;
   logic [GAIN_BITS-1:0] cfg_output = OUTPUT_RESET;

   feedback_echo_delay dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_dry_sample(req_dry_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_sample(rsp_out_sample),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #6 clock = ~clock;

   function automatic sample_type clamp_sample(longint v);
      if (v > SAMPLE_MAX) return sample_type'(SAMPLE_MAX);
      if (v < SAMPLE_MIN) return sample_type'(SAMPLE_MIN);
      return sample_type'(v);
   endfunction

   // Q1.15 multiply, round half up, saturate
   function automatic sample_type q15_scale(sample_type x, logic [GAIN_BITS-1:0] g);
      longint p;
      p = longint'(x) * longint'(g);
      return clamp_sample((p + 16384) >>> 15);
   endfunction

   function automatic sample_type echo_mix(sample_type dry);
      logic [RING_ADDR_BITS-1:0] rd_pos;
      sample_type wet;
      sample_type mix;
      sample_type fb;
      rd_pos = RING_ADDR_BITS'(echo_wr_pos - cfg_delay);
      wet = echo_ring[rd_pos];
      mix = clamp_sample(longint'(dry) + longint'(q15_scale(wet, cfg_wet)));
      fb = clamp_sample(longint'(dry) + longint'(q15_scale(wet, cfg_feedback)));
      echo_ring[echo_wr_pos] = fb;
      echo_wr_pos = echo_wr_pos + 1'b1;
      return q15_scale(mix, cfg_output);
   endfunction

   task automatic report_mismatch(string what);
      $display("ERROR: %s", what);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_out.push_back(echo_mix(req_dry_sample));
         end
         if (!req_valid || !req_stall) begin
            if (pending_dry.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_dry_sample <= pending_dry.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_go) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, out_sample %0d", rsp_out_sample));
         end else if (rsp_out_sample !== expected_out[0]) begin
            report_mismatch($sformatf("transaction %0d: out_sample %0d, expected %0d",
                                      result_count, rsp_out_sample, expected_out[0]));
            void'(expected_out.pop_front());
         end else begin
            void'(expected_out.pop_front());
         end
         result_count++;
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
   end

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'({idx, 2'b00});
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_DELAY:    cfg_delay = data[DELAY_BITS-1:0];
         REG_FEEDBACK: cfg_feedback = data[GAIN_BITS-1:0];
         REG_WET:      cfg_wet = data[GAIN_BITS-1:0];
         REG_OUTPUT:   cfg_output = data[GAIN_BITS-1:0];
         default: ;
      endcase
   endtask

   // upper bits of each write are random junk
   task automatic set_echo(logic [DELAY_BITS-1:0] delay, logic [GAIN_BITS-1:0] fb,
                           logic [GAIN_BITS-1:0] wet, logic [GAIN_BITS-1:0] vol);
      logic [CSR_DATA_BITS-1:0] d;
      d = $urandom; d[DELAY_BITS-1:0] = delay; csr_write(REG_DELAY, d);
      d = $urandom; d[GAIN_BITS-1:0] = fb;     csr_write(REG_FEEDBACK, d);
      d = $urandom; d[GAIN_BITS-1:0] = wet;    csr_write(REG_WET, d);
      d = $urandom; d[GAIN_BITS-1:0] = vol;    csr_write(REG_OUTPUT, d);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_dry.size() != 0 || req_valid || expected_out.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [GAIN_BITS-1:0] pick_gain();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return GAIN_BITS'($urandom);
      endcase
   endfunction

   function automatic sample_type random_dry();
      case ($urandom_range(9))
         0, 1: return sample_type'($urandom_range(1023)) - 16'sd512;
         2: begin
            case ($urandom_range(3))
               0: return sample_type'(SAMPLE_MAX);
               1: return sample_type'(SAMPLE_MIN);
               2: return '0;
               default: return '1;
            endcase
         end
         default: return sample_type'($urandom);
      endcase
   endfunction

   initial begin
      logic [DELAY_BITS-1:0] delay;
      foreach (echo_ring[i]) echo_ring[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, wet path still empty
      pending_dry = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001,
                      16'sh5555, 16'shaaaa};
      wait_drained();
      // one-sample echo, full gains: saturation on every path
      set_echo(16'd1, '1, '1, '1);
      pending_dry = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
                      16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000};
      wait_drained();
      // zero delay (upper write bits random), then the longest delay
      set_echo(16'd0, FEEDBACK_RESET, WET_RESET, WET_RESET);
      pending_dry = '{16'sh1234, 16'shedcb, 16'sh7fff};
      wait_drained();
      set_echo(16'hffff, '1, '1, OUTPUT_RESET);
      pending_dry = '{16'sh4000, 16'shc000};
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 23; recv_idle_pct = 62;
         end else if (ph < 6) begin
            send_idle_pct = 62; recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         case (ph)
            0: set_echo(16'd1, '1, '1, '1);
            4: set_echo(16'hffff, pick_gain(), pick_gain(), pick_gain());
            5: set_echo(DELAY_BITS'($urandom_range(1, 48)), '0, '0, '0);
            default: begin
               delay = ($urandom_range(4) == 0) ? DELAY_BITS'($urandom_range(1, 65535))
                                                : DELAY_BITS'($urandom_range(1, 48));
               set_echo(delay, pick_gain(), pick_gain(), pick_gain());
            end
         endcase
         repeat (PHASE_ITEMS) pending_dry.push_back(random_dry());
         if (ph == 3) begin
            @(posedge clock);
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         // a stretch without gaps in the middle of each phase
         if (ph < 6) begin
            wait (pending_dry.size() < PHASE_ITEMS / 2);
            send_idle_pct = 0; recv_idle_pct = 0;
            repeat (60) @(posedge clock);
            send_idle_pct = (ph < 3) ? 23 : 62;
            recv_idle_pct = (ph < 3) ? 62 : 23;
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> feedback_echo_delay.f
rtl/fed_pkg.sv
rtl/fed_serial_mult.sv
rtl/fed_delay_ring.sv
rtl/fed_csr.sv
rtl/feedback_echo_delay.sv
bench/feedback_echo_delay_test.sv
